/* sv/frp_pkg.sv */
// Shared types, constants and codes of the framed packet receiver.
`default_nettype none

package frp_pkg;

    // Default payload capacity of one frame
    localparam int MAX_PAYLOAD_BYTES_DEF = 32;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Configuration register reset values
    localparam logic [7:0] OWN_NODE_RST   = 8'h01;
    localparam logic [7:0] START_BYTE_RST = 8'hA6;

    // Configuration register indexes
    localparam int          CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b1;

    // Output beat layout
    localparam int OUT_TDATA_W = 32;

    // Frame parse phase
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_NODE   = 3'd1,
        PH_CMD    = 3'd2,
        PH_LEN    = 3'd3,
        PH_DATA   = 3'd4,
        PH_CHK_LO = 3'd5,
        PH_CHK_HI = 3'd6
    } t_phase;

    // Sequencer state
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CRC  = 2'd1,
        ST_READ = 2'd2,
        ST_EMIT = 2'd3
    } t_state;

    // Commands to the CRC unit
    typedef struct packed {
        logic       init;
        logic       start;
        logic [7:0] data;
    } t_crc_ctrl;

    // Status from the CRC unit
    typedef struct packed {
        logic        busy;
        logic [15:0] value;
    } t_crc_stat;

endpackage

`default_nettype wire

/* sv/framed_packet_receiver_top.sv */
// Framed packet receiver: head search, CRC-16 check and payload replay.
//
// Bytes arrive one per beat on the slave stream. After the start byte the
// block takes node, command and length bytes, up to MAX_PAYLOAD_BYTES payload
// bytes and a CRC-16/CCITT-FALSE sent low byte first. A good frame for this
// node is replayed on the master stream, one beat per payload byte (one beat
// with zero data for an empty frame), tlast on the final beat; bad frames
// vanish. Node, command, accepted length and payload bytes each start the
// bit-serial CRC unit (one polynomial step per cycle); no byte is taken
// until it is done. Bytes seen while hunting, a length byte above the
// maximum and the check bytes do not use it. Replay reads each payload byte
// from the RAM, then offers its beat, held through any master stall; an empty
// frame goes straight to its single beat. No byte is taken during replay.
`default_nettype none

module framed_packet_receiver_top #(
    parameter int MAX_PAYLOAD_BYTES = frp_pkg::MAX_PAYLOAD_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [frp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                    i_cfg_data,
    // Received bytes
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
    // Frame payload beats
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [7:0] frame_command, [13:8] frame_length, [21:14] data_byte,
    // [26:22] byte_position, [31:27] zero
    output logic [frp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast    // end_of_frame
);

    import frp_pkg::*;

    localparam int LEN_W  = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int ADDR_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_own, n_own;
    logic [7:0]  r_start, n_start;
    logic [7:0]  r_node, n_node;
    logic [7:0]  r_cmd, n_cmd;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_count, n_count;
    logic [7:0]  r_chk_lo, n_chk_lo;

    t_crc_ctrl   w_crc_ctrl;
    t_crc_stat   w_crc_stat;
    logic        w_in_beat;
    logic        w_out_beat;
    logic        w_ram_wr;
    logic [7:0]  w_ram_rd;
    logic [LEN_W-1:0] w_count_inc;
    logic        w_last;
    logic [7:0]  w_data;
    logic [LEN_W+5:0] w_len_ext;
    logic [LEN_W+4:0] w_pos_ext;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign w_out_beat    = m_axis_tvalid && m_axis_tready;
    assign w_count_inc   = r_count + LEN_W'(1);

    // Payload store
    frp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD_BYTES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_addr (r_count[ADDR_W-1:0]),
        .o_rd_data (w_ram_rd)
    );

    // Shared CRC unit
    frp_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_crc_ctrl),
        .o_stat  (w_crc_stat)
    );

    // Sequencer: parse bytes, drive the CRC unit, replay payload
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_own    = r_own;
        n_start  = r_start;
        n_node   = r_node;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_count  = r_count;
        n_chk_lo = r_chk_lo;
        w_crc_ctrl.init  = 1'b0;
        w_crc_ctrl.start = 1'b0;
        w_crc_ctrl.data  = s_axis_tdata;
        w_ram_wr = 1'b0;

        // Configuration writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OWN_NODE:   n_own   = i_cfg_data;
                CFG_START_BYTE: n_start = i_cfg_data;
                default:        ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_beat) begin
                    case (r_phase)
                        PH_HUNT: begin
                            if (s_axis_tdata == r_start) begin
                                w_crc_ctrl.init = 1'b1;
                                n_phase = PH_NODE;
                            end
                        end
                        PH_NODE: begin
                            n_node = s_axis_tdata;
                            w_crc_ctrl.start = 1'b1;
                            n_phase = PH_CMD;
                            n_state = ST_CRC;
                        end
                        PH_CMD: begin
                            n_cmd = s_axis_tdata;
                            w_crc_ctrl.start = 1'b1;
                            n_phase = PH_LEN;
                            n_state = ST_CRC;
                        end
                        PH_LEN: begin
                            n_count = '0;
                            if ({1'b0, s_axis_tdata} > 9'(MAX_PAYLOAD_BYTES)) begin
                                n_phase = PH_HUNT;
                            end else begin
                                n_len = s_axis_tdata[LEN_W-1:0];
                                w_crc_ctrl.start = 1'b1;
                                n_state = ST_CRC;
                                if (s_axis_tdata == 8'd0) begin
                                    n_phase = PH_CHK_LO;
                                end else begin
                                    n_phase = PH_DATA;
                                end
                            end
                        end
                        PH_DATA: begin
                            w_ram_wr = 1'b1;
                            n_count = w_count_inc;
                            w_crc_ctrl.start = 1'b1;
                            n_state = ST_CRC;
                            if (w_count_inc >= r_len) begin
                                n_phase = PH_CHK_LO;
                            end
                        end
                        PH_CHK_LO: begin
                            n_chk_lo = s_axis_tdata;
                            n_phase = PH_CHK_HI;
                        end
                        PH_CHK_HI: begin
                            n_phase = PH_HUNT;
                            if ((r_node == r_own) &&
                                ({s_axis_tdata, r_chk_lo} == w_crc_stat.value)) begin
                                n_count = '0;
                                if (r_len == '0) begin
                                    n_state = ST_EMIT;
                                end else begin
                                    n_state = ST_READ;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_HUNT;
                        end
                    endcase
                end
            end
            ST_CRC: begin
                if (!w_crc_stat.busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_beat) begin
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_count = w_count_inc;
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_HUNT;
            r_own    <= OWN_NODE_RST;
            r_start  <= START_BYTE_RST;
            r_node   <= 8'd0;
            r_cmd    <= 8'd0;
            r_len    <= '0;
            r_count  <= '0;
            r_chk_lo <= 8'd0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_own    <= n_own;
            r_start  <= n_start;
            r_node   <= n_node;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
            r_count  <= n_count;
            r_chk_lo <= n_chk_lo;
        end
    end

    // Output beat
    assign w_last    = (r_len == '0) || (w_count_inc == r_len);
    assign w_data    = (r_len == '0) ? 8'd0 : w_ram_rd;
    assign w_len_ext = {6'd0, r_len};
    assign w_pos_ext = {5'd0, r_count};

    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign m_axis_tlast  = w_last;
    assign m_axis_tdata  = {5'd0, w_pos_ext[4:0], w_data, w_len_ext[5:0], r_cmd};

endmodule

`default_nettype wire

/* sv/frp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module frp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* sv/frp_crc.sv */
// Bit-serial CRC-16/CCITT-FALSE unit, one polynomial step per cycle.
`default_nettype none

module frp_crc (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire frp_pkg::t_crc_ctrl i_ctrl,
    output frp_pkg::t_crc_stat     o_stat
);

    import frp_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [3:0]  r_bits;
    logic [3:0]  n_bits;

    // Load, fold in a byte, or shift one bit
    always_comb begin
        n_crc  = r_crc;
        n_bits = r_bits;
        if (i_ctrl.init) begin
            n_crc  = CRC_INIT;
            n_bits = 4'd0;
        end else if (i_ctrl.start) begin
            n_crc  = r_crc ^ {i_ctrl.data, 8'h00};
            n_bits = 4'd8;
        end else if (r_bits != 4'd0) begin
            if (r_crc[15]) begin
                n_crc = {r_crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                n_crc = {r_crc[14:0], 1'b0};
            end
            n_bits = r_bits - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_bits <= 4'd0;
        end else begin
            r_crc  <= n_crc;
            r_bits <= n_bits;
        end
    end

    assign o_stat.busy  = (r_bits != 4'd0);
    assign o_stat.value = r_crc;

endmodule

`default_nettype wire
